FILE: rtl/msr_pkg.sv
package msr_pkg;

	// Default ramp counter width
	localparam int RAMP_BITS_DEF = 16;

	// Fixed field widths
	localparam int SPEED_W    = 8;
	localparam int FIELD_W    = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	// Full-scale speed
	localparam logic [SPEED_W-1:0] SPEED_FULL = 8'd255;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] MIN_POWER_RST = 8'd40;
	localparam logic [CFG_DATA_W-1:0] MAX_POWER_RST = 8'd200;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = 8'd1;

	// Item operation codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic mul_en;
		logic div_step;
		logic speed_en;
		logic dmul_en;
		logic out_load;
	} msr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic at_goal;
	} msr_status_t;

endpackage

FILE: rtl/msr_in_if.sv
interface msr_in_if import msr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [FIELD_W-1:0] target_speed;
	logic [FIELD_W-1:0] ramp_ms;

	modport source (output valid, output op, output target_speed, output ramp_ms, input ready);
	modport sink (input valid, input op, input target_speed, input ramp_ms, output ready);
endinterface

FILE: rtl/msr_out_if.sv
interface msr_out_if import msr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] speed;
	logic [SPEED_W-1:0] duty;

	modport source (output valid, output speed, output duty, input ready);
	modport sink (input valid, input speed, input duty, output ready);
endinterface

FILE: rtl/msr_cfg_if.sv
interface msr_cfg_if import msr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/msr_ctrl.sv
module msr_ctrl import msr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  msr_status_t status,
	output msr_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SPEED = 3'd3;
	localparam logic [2:0] ST_DMUL  = 3'd4;
	localparam logic [2:0] ST_DUTY  = 3'd5;

	localparam int DIV_STEPS = SPEED_W;

	logic [2:0]                   state_q, state_d;
	logic [$clog2(DIV_STEPS)-1:0] step_q;
	logic                         out_valid_q;
	logic                         out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = status.at_goal ? ST_SPEED : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '1) state_d = ST_SPEED;
			end
			ST_SPEED: begin
				cmd.speed_en = 1'b1;
				state_d      = ST_DMUL;
			end
			ST_DMUL: begin
				cmd.dmul_en = 1'b1;
				state_d     = ST_DUTY;
			end
			ST_DUTY: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state, divide step count and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) step_q <= step_q + 1'b1;
			else step_q <= '0;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/msr_dpath.sv
module msr_dpath import msr_pkg::*; #(
	parameter int RAMP_BITS = RAMP_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  msr_cmd_t              cmd,
	output msr_status_t           status,
	input  logic                  op,
	input  logic [FIELD_W-1:0]    target_speed,
	input  logic [FIELD_W-1:0]    ramp_ms,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [SPEED_W-1:0]    speed,
	output logic [SPEED_W-1:0]    duty
);

	localparam int EXT_W  = (RAMP_BITS > FIELD_W) ? RAMP_BITS : FIELD_W;
	localparam int PROD_W = SPEED_W + RAMP_BITS;
	localparam logic [RAMP_BITS-1:0] RAMP_MAX = {RAMP_BITS{1'b1}};

	// Ramp state
	logic [SPEED_W-1:0]   cur_q, start_q, goal_q;
	logic [RAMP_BITS-1:0] elapsed_q, len_q;
	logic [CFG_DATA_W-1:0] min_q, max_q;

	// Divider and duty working registers
	logic [RAMP_BITS-1:0] rem_q;
	logic [SPEED_W-1:0]   lo_q, quo_q;
	logic [2*SPEED_W-1:0] dprod_q;
	logic [SPEED_W-1:0]   speed_q, duty_q;

	logic [EXT_W-1:0]     ramp_ext;
	logic [RAMP_BITS-1:0] len_sat;
	logic [SPEED_W-1:0]   goal_clamp;
	logic                 desc;
	logic [SPEED_W-1:0]   mag;
	logic [PROD_W-1:0]    prod;
	logic [RAMP_BITS:0]   trial;
	logic                 fits;
	logic                 dneg;
	logic [SPEED_W-1:0]   span;
	logic [SPEED_W-1:0]   dq;
	logic [SPEED_W:0]     dr;
	logic [SPEED_W-1:0]   dqf;
	logic [SPEED_W-1:0]   duty_d;

	// Clamp request fields
	assign ramp_ext   = EXT_W'(ramp_ms);
	assign len_sat    = (ramp_ext > EXT_W'(RAMP_MAX)) ? RAMP_MAX : ramp_ext[RAMP_BITS-1:0];
	assign goal_clamp = (target_speed > FIELD_W'(SPEED_FULL)) ? SPEED_FULL
	                                                          : target_speed[SPEED_W-1:0];

	// Ramp step magnitude and product
	assign status.at_goal = (elapsed_q >= len_q);
	assign desc = (goal_q < start_q);
	assign mag  = desc ? (start_q - goal_q) : (goal_q - start_q);
	assign prod = PROD_W'(mag) * PROD_W'(elapsed_q);

	// One restoring divide step
	assign trial = {rem_q, lo_q[SPEED_W-1]};
	assign fits  = (trial >= {1'b0, len_q});

	// Duty span and divide by 255: quotient is hi byte plus a carry fix
	assign dneg   = (max_q < min_q);
	assign span   = dneg ? (min_q - max_q) : (max_q - min_q);
	assign dq     = dprod_q[2*SPEED_W-1:SPEED_W];
	assign dr     = {1'b0, dprod_q[SPEED_W-1:0]} + {1'b0, dq};
	assign dqf    = dq + SPEED_W'(dr >= {1'b0, SPEED_FULL});
	assign duty_d = (cur_q == '0) ? '0 : (dneg ? (min_q - dqf) : (min_q + dqf));

	// Hold ramp state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			start_q   <= '0;
			goal_q    <= '0;
			elapsed_q <= '0;
			len_q     <= '0;
			min_q     <= MIN_POWER_RST;
			max_q     <= MAX_POWER_RST;
		end else begin
			if (cfg_we && cfg_index == REG_MIN_POWER) min_q <= cfg_data;
			if (cfg_we && cfg_index == REG_MAX_POWER) max_q <= cfg_data;
			if (cmd.accept) begin
				if (op == OP_REQUEST) begin
					start_q   <= cur_q;
					goal_q    <= goal_clamp;
					len_q     <= len_sat;
					elapsed_q <= '0;
				end else if (elapsed_q != RAMP_MAX) begin
					elapsed_q <= elapsed_q + 1'b1;
				end
			end
			if (cmd.speed_en) begin
				if (status.at_goal) cur_q <= goal_q;
				else if (desc) cur_q <= start_q - quo_q;
				else cur_q <= start_q + quo_q;
			end
		end
	end

	// Multiply, divide and map to duty
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			rem_q <= prod[PROD_W-1:SPEED_W];
			lo_q  <= prod[SPEED_W-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? RAMP_BITS'(trial - {1'b0, len_q}) : trial[RAMP_BITS-1:0];
			lo_q  <= {lo_q[SPEED_W-2:0], 1'b0};
			quo_q <= {quo_q[SPEED_W-2:0], fits};
		end
		if (cmd.dmul_en) dprod_q <= (2*SPEED_W)'(cur_q) * (2*SPEED_W)'(span);
		if (cmd.out_load) begin
			speed_q <= cur_q;
			duty_q  <= duty_d;
		end
	end

	assign speed = speed_q;
	assign duty  = duty_q;

endmodule

FILE: rtl/motor_speed_ramp_pwm_core.sv
// Linear speed ramp with PWM duty mapping. Each input item (a one millisecond
// tick or a new speed request) yields one item holding the ramped speed and its
// duty. An accepted item passes through the multiply, divide, speed, duty-multiply
// and duty states in that order, skipping the divide once the ramp has reached its
// goal; the 8-step restoring divider for the ramp quotient yields one quotient bit
// per cycle. The next item is accepted once the previous result sits in the output
// register, so an item is not taken while another is still in progress. Registers
// min_power (index 0) and max_power (index 1) are written through the configuration
// channel and are used by every item whose duty mapping is still to come.
module motor_speed_ramp_pwm_core import msr_pkg::*; #(
	parameter int RAMP_BITS = RAMP_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	msr_in_if.sink        in_ch,
	msr_out_if.source     out_ch,
	msr_cfg_if.sink       cfg
);

	msr_cmd_t    cmd;
	msr_status_t status;

	// Take register writes at any time
	assign cfg.ready = 1'b1;

	msr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	msr_dpath #(
		.RAMP_BITS (RAMP_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.op           (in_ch.op),
		.target_speed (in_ch.target_speed),
		.ramp_ms      (in_ch.ramp_ms),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.speed        (out_ch.speed),
		.duty         (out_ch.duty)
	);

endmodule

FILE: test/tb_motor_speed_ramp_pwm_core.sv
module tb_motor_speed_ramp_pwm_core;
	import msr_pkg::*;

	localparam int RAMP_W = RAMP_BITS_DEF;
	localparam longint unsigned RAMP_MAX = (64'd1 << RAMP_W) - 1;
	localparam int DRAIN_CYCLES = 24;
	localparam int LIMIT = 5000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 120;
	localparam int N_PHASES = 8;
	localparam int PLAN_ROWS = 24;
	localparam logic PIN = 1'b1;
	localparam logic FREE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(REG_MAX_POWER + 1);
	localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX = '1;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [SPEED_W-1:0] duty;
	} drive_t;

	typedef struct packed {
		logic               op;
		logic [FIELD_W-1:0] tgt;
		logic [FIELD_W-1:0] len;
		logic               pinned;
		drive_t             want;
	} row_t;

	// Directed rows; pinned rows carry the drive read straight off the spec
	row_t plan [PLAN_ROWS] = '{
		{OP_TICK,    16'h0000, 16'h0000, PIN,  8'd0,   8'd0},
		{OP_REQUEST, 16'd255,  16'd0,    PIN,  8'd255, 8'd200},
		{OP_REQUEST, 16'hFFFF, 16'd0,    PIN,  8'd255, 8'd200},
		{OP_REQUEST, 16'd0,    16'd0,    PIN,  8'd0,   8'd0},
		{OP_REQUEST, 16'd300,  16'd4,    PIN,  8'd0,   8'd0},
		{OP_TICK,    16'h0000, 16'h0000, FREE, 8'd0,   8'd0},
		{OP_TICK,    16'hFFFF, 16'hFFFF, FREE, 8'd0,   8'd0},
		{OP_TICK,    16'h0000, 16'h0000, FREE, 8'd0,   8'd0},
		{OP_TICK,    16'h0000, 16'h0000, PIN,  8'd255, 8'd200},
		{OP_TICK,    16'h0000, 16'h0000, PIN,  8'd255, 8'd200},
		{OP_REQUEST, 16'd0,    16'd3,    PIN,  8'd255, 8'd200},
		{OP_TICK,    16'h0000, 16'h0000, FREE, 8'd0,   8'd0},
		{OP_TICK,    16'h0000, 16'h0000, FREE, 8'd0,   8'd0},
		{OP_TICK,    16'h0000, 16'h0000, PIN,  8'd0,   8'd0},
		{OP_REQUEST, 16'd1,    16'hFFFF, PIN,  8'd0,   8'd0},
		{OP_TICK,    16'h0000, 16'h0000, PIN,  8'd0,   8'd0},
		{OP_REQUEST, 16'd1,    16'd0,    PIN,  8'd1,   8'd40},
		{OP_REQUEST, 16'd254,  16'd2,    FREE, 8'd0,   8'd0},
		{OP_TICK,    16'h0000, 16'h0000, FREE, 8'd0,   8'd0},
		{OP_TICK,    16'h0000, 16'h0000, FREE, 8'd0,   8'd0},
		{OP_REQUEST, 16'hAAAA, 16'h5555, FREE, 8'd0,   8'd0},
		{OP_TICK,    16'h5555, 16'hAAAA, FREE, 8'd0,   8'd0},
		{OP_REQUEST, 16'd128,  16'd1,    FREE, 8'd0,   8'd0},
		{OP_TICK,    16'hFFFF, 16'hFFFF, FREE, 8'd0,   8'd0}
	};

	logic clk;
	logic arst_n;

	msr_in_if  in_ch ();
	msr_out_if out_ch ();
	msr_cfg_if cfg_ch ();

	motor_speed_ramp_pwm_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state
	logic [SPEED_W-1:0]    ramp_now;
	logic [SPEED_W-1:0]    ramp_from;
	logic [SPEED_W-1:0]    ramp_goal;
	logic [RAMP_W-1:0]     ms_elapsed;
	logic [RAMP_W-1:0]     ms_length;
	logic [CFG_DATA_W-1:0] pwr_min;
	logic [CFG_DATA_W-1:0] pwr_max;

	drive_t drive_q [$];
	drive_t seen_want;
	int     send_idle;
	int     recv_stall;
	int     hold_left;
	int     items_sent;
	int     results_seen;
	int     errs;
	int     quiet;
	int     settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [SPEED_W-1:0] duty_for(logic [SPEED_W-1:0] s);
		longint unsigned span;
		logic [SPEED_W-1:0] d;
		if (s == 0)
			return '0;
		if (pwr_max >= pwr_min) begin
			span = pwr_max - pwr_min;
			d = SPEED_W'(pwr_min + (s * span) / SPEED_FULL);
		end else begin
			span = pwr_min - pwr_max;
			d = SPEED_W'(pwr_min - (s * span) / SPEED_FULL);
		end
		return d;
	endfunction

	// Advance the ramp by one item and return the drive it produces
	function automatic drive_t step_drive(logic op, logic [FIELD_W-1:0] tgt,
			logic [FIELD_W-1:0] len);
		longint unsigned mag;
		longint unsigned q;
		drive_t d;
		if (op == OP_REQUEST) begin
			ramp_from = ramp_now;
			ramp_goal = (tgt > SPEED_FULL) ? SPEED_FULL : tgt[SPEED_W-1:0];
			ms_length = RAMP_W'((len > RAMP_MAX) ? RAMP_MAX : len);
			ms_elapsed = '0;
		end else if (ms_elapsed < RAMP_MAX) begin
			ms_elapsed = ms_elapsed + 1'b1;
		end
		if (ms_elapsed >= ms_length) begin
			ramp_now = ramp_goal;
		end else if (ramp_goal >= ramp_from) begin
			mag = ramp_goal - ramp_from;
			q = (mag * ms_elapsed) / ms_length;
			ramp_now = SPEED_W'(ramp_from + q);
		end else begin
			// descending: truncate the magnitude, then subtract
			mag = ramp_from - ramp_goal;
			q = (mag * ms_elapsed) / ms_length;
			ramp_now = SPEED_W'(ramp_from - q);
		end
		d.speed = ramp_now;
		d.duty = duty_for(ramp_now);
		return d;
	endfunction

	// Offer one item after a random gap, then record its expected drive
	task automatic send_item(logic op, logic [FIELD_W-1:0] tgt, logic [FIELD_W-1:0] len,
			logic pinned, drive_t want);
		int gap;
		drive_t d;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle)
			gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.target_speed <= tgt;
		in_ch.ramp_ms <= len;
		do @(posedge clk); while (!in_ch.ready);
		d = step_drive(op, tgt, len);
		drive_q.push_back(pinned ? want : d);
		items_sent++;
	endtask

	// Drop valid and hold until every expected item is back and the core is quiet
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_MIN_POWER)
			pwr_min = val;
		else if (idx == REG_MAX_POWER)
			pwr_max = val;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// One request followed by a run of ticks, or now and then a stray item or a settle
	task automatic ramp_burst();
		int pick;
		int n;
		logic [FIELD_W-1:0] tgt;
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] junk_a;
		logic [FIELD_W-1:0] junk_b;
		pick = $urandom_range(99);
		junk_a = FIELD_W'($urandom);
		junk_b = FIELD_W'($urandom);
		if (pick < 3) begin
			settle();
			return;
		end
		if (pick < 12) begin
			send_item(pick[0] ? OP_REQUEST : OP_TICK, junk_a, junk_b, FREE, '0);
			return;
		end
		pick = $urandom_range(99);
		if (pick < 60)
			tgt = FIELD_W'($urandom_range(255));
		else if (pick < 70)
			tgt = pick[0] ? FIELD_W'(SPEED_FULL) : '0;
		else if (pick < 80)
			tgt = FIELD_W'($urandom_range(300, 256));
		else
			tgt = FIELD_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 50)
			len = FIELD_W'($urandom_range(24));
		else if (pick < 70)
			len = FIELD_W'($urandom_range(300, 25));
		else if (pick < 85)
			len = FIELD_W'($urandom);
		else
			len = FIELD_W'($urandom_range(16'hFFFF, 16'hFFF0));
		send_item(OP_REQUEST, tgt, len, FREE, '0);
		n = (len <= 40) ? int'(len) + $urandom_range(3) : $urandom_range(30);
		// cut some ramps short so a new request lands mid-ramp
		if ($urandom_range(9) == 0)
			n = $urandom_range(n);
		repeat (n) begin
			junk_a = FIELD_W'($urandom);
			junk_b = FIELD_W'($urandom);
			send_item(OP_TICK, junk_a, junk_b, FREE, '0);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off counted here
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Check each returned item against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (drive_q.size() == 0) begin
				errs++;
				$display("%0t: unexpected item: expected none, got speed %0d duty %0d",
					$time, out_ch.speed, out_ch.duty);
			end else begin
				seen_want = drive_q.pop_front();
				results_seen++;
				if (out_ch.speed !== seen_want.speed) begin
					errs++;
					$display("%0t: speed mismatch: expected %0d, got %0d",
						$time, seen_want.speed, out_ch.speed);
				end
				if (out_ch.duty !== seen_want.duty) begin
					errs++;
					$display("%0t: duty mismatch: expected %0d, got %0d",
						$time, seen_want.duty, out_ch.duty);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d items outstanding",
				$time, LIMIT, drive_q.size());
			$display("tb_motor_speed_ramp_pwm_core: FAIL");
			$finish;
		end
	end

	initial begin
		int p;
		int first;
		int tail_ticks;
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_TICK;
		in_ch.target_speed = '0;
		in_ch.ramp_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MIN_POWER;
		cfg_ch.data = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_left = 0;
		items_sent = 0;
		results_seen = 0;
		errs = 0;
		quiet = 0;
		settings_used = 1;
		ramp_now = '0;
		ramp_from = '0;
		ramp_goal = '0;
		ms_elapsed = '0;
		ms_length = '0;
		pwr_min = MIN_POWER_RST;
		pwr_max = MAX_POWER_RST;
		tail_ticks = 6;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset power settings
		for (int i = 0; i < PLAN_ROWS; i++)
			send_item(plan[i].op, plan[i].tgt, plan[i].len, plan[i].pinned, plan[i].want);

		// Short ramp, then tick well past its end
		send_item(OP_REQUEST, 16'd200, 16'd1, FREE, '0);
		repeat (tail_ticks) send_item(OP_TICK, '0, '0, FREE, '0);
		settle();

		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin lo = '0; hi = '1; end
				1: begin lo = '1; hi = '0; end
				2: begin lo = '0; hi = '0; end
				3: begin lo = '1; hi = '1; end
				4: begin lo = 8'd200; hi = 8'd40; end
				5: begin lo = 8'd100; hi = 8'd100; end
				default: begin lo = CFG_DATA_W'($urandom); hi = CFG_DATA_W'($urandom); end
			endcase
			write_reg(REG_MIN_POWER, lo);
			write_reg(REG_MAX_POWER, hi);
			if (p == 4) begin
				// writes outside the register map must change nothing
				write_reg(REG_UNUSED, 8'h5A);
				write_reg(REG_TOP_IDX, 8'hA5);
			end
			settings_used++;
			case (p % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 49; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 49; end
				default: begin send_idle = 37; recv_stall = 37; end
			endcase
			if (p % 4 == 0)
				hold_left = HOLD_CYCLES;
			first = items_sent;
			while (items_sent - first < PHASE_ITEMS)
				ramp_burst();
			settle();
		end

		$display("Ran %0d directed rows, a short ramp with %0d trailing ticks and random ramps",
			PLAN_ROWS, tail_ticks);
		$display("over %0d power settings: %0d items sent, %0d checked, %0d mismatches",
			settings_used, items_sent, results_seen, errs);
		if (errs == 0)
			$display("tb_motor_speed_ramp_pwm_core: PASS");
		else
			$display("tb_motor_speed_ramp_pwm_core: FAIL");
		$finish;
	end

endmodule
